// ----- design/rtcm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the RTC match-counter register block: opcodes, register offsets,
// request and result payload types. No dependencies.
package rtcm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OfsW  = 8;
  localparam int unsigned OpW   = 2;

  // Request opcodes; the fourth code is a no-op.
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_e;

  // Register byte offsets
  localparam logic [OfsW-1:0] OFS_DATA    = 8'h00;
  localparam logic [OfsW-1:0] OFS_MATCH   = 8'h04;
  localparam logic [OfsW-1:0] OFS_LOAD    = 8'h08;
  localparam logic [OfsW-1:0] OFS_CONTROL = 8'h0C;
  localparam logic [OfsW-1:0] OFS_MASK    = 8'h10;
  localparam logic [OfsW-1:0] OFS_RAW     = 8'h14;
  localparam logic [OfsW-1:0] OFS_MASKED  = 8'h18;
  localparam logic [OfsW-1:0] OFS_CLEAR   = 8'h1C;

  // Single-bit flags live in bit 0 of their registers.
  localparam int unsigned FlagBit = 0;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [OfsW-1:0]  reg_offset;
    logic [DataW-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             alarm_hit;
    logic             irq_level;
  } res_t;

endpackage

// ----- design/rtcm_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on rtcm_pkg for field widths.
interface rtcm_req_if;
  logic                        valid;
  logic                        ready;
  logic [rtcm_pkg::OpW-1:0]    opcode;
  logic [rtcm_pkg::OfsW-1:0]   reg_offset;
  logic [rtcm_pkg::DataW-1:0]  write_data;

  modport source (output valid, output opcode, output reg_offset, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input reg_offset, input write_data,
                  output ready);
endinterface

interface rtcm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rtcm_pkg::DataW-1:0]  read_data;
  logic                        alarm_hit;
  logic                        irq_level;

  modport source (output valid, output read_data, output alarm_hit, output irq_level,
                  input ready);
  modport sink   (input valid, input read_data, input alarm_hit, input irq_level,
                  output ready);
endinterface

// ----- design/rtcm_in_stage.sv -----
`timescale 1ns / 1ps
// Request input register: captures one request and hands it to the register core.
// Depends on rtcm_pkg.
module rtcm_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rtcm_pkg::req_t req_i,
  input  logic           slot_free_i,
  output logic           exec_o,
  output rtcm_pkg::req_t req_o
);

  logic           valid_q, valid_d;
  rtcm_pkg::req_t req_q;

  // Request executes when held here and the result register can take it.
  assign exec_o  = valid_q & slot_free_i;
  assign ready_o = ~valid_q | exec_o;
  assign req_o   = req_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
    end
  end

endmodule

// ----- design/rtcm_regs.sv -----
`timescale 1ns / 1ps
// Register core: counter, match, load, enable, mask and raw alarm state,
// with the tick / read / write decode. Depends on rtcm_pkg.
module rtcm_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           exec_i,
  input  rtcm_pkg::req_t req_i,
  output rtcm_pkg::res_t res_o
);

  logic [rtcm_pkg::DataW-1:0] count_q, count_d;
  logic [rtcm_pkg::DataW-1:0] match_q, match_d;
  logic [rtcm_pkg::DataW-1:0] load_q, load_d;
  logic                       run_en_q, run_en_d;
  logic                       mask_q, mask_d;
  logic                       raw_q, raw_d;

  logic [rtcm_pkg::DataW-1:0] count_inc;
  logic [rtcm_pkg::DataW-1:0] rdata;
  logic                       hit;
  logic                       wbit;

  assign count_inc = count_q + rtcm_pkg::DataW'(1);
  assign wbit      = req_i.write_data[rtcm_pkg::FlagBit];

  always_comb begin
    count_d  = count_q;
    match_d  = match_q;
    load_d   = load_q;
    run_en_d = run_en_q;
    mask_d   = mask_q;
    raw_d    = raw_q;
    rdata    = '0;
    hit      = 1'b0;
    case (rtcm_pkg::opcode_e'(req_i.opcode))
      rtcm_pkg::OP_TICK: begin
        if (run_en_q) begin
          count_d = count_inc;
          if (count_inc == match_q) begin
            raw_d = 1'b1;
            hit   = 1'b1;
          end
        end
      end
      rtcm_pkg::OP_READ: begin
        case (req_i.reg_offset)
          rtcm_pkg::OFS_DATA:    rdata = count_q;
          rtcm_pkg::OFS_MATCH:   rdata = match_q;
          rtcm_pkg::OFS_LOAD:    rdata = load_q;
          rtcm_pkg::OFS_CONTROL: rdata = rtcm_pkg::DataW'(run_en_q);
          rtcm_pkg::OFS_MASK:    rdata = rtcm_pkg::DataW'(mask_q);
          rtcm_pkg::OFS_RAW:     rdata = rtcm_pkg::DataW'(raw_q);
          rtcm_pkg::OFS_MASKED:  rdata = rtcm_pkg::DataW'(raw_q & mask_q);
          default:               rdata = '0;
        endcase
      end
      rtcm_pkg::OP_WRITE: begin
        case (req_i.reg_offset)
          rtcm_pkg::OFS_MATCH: match_d = req_i.write_data;
          rtcm_pkg::OFS_LOAD: begin
            load_d  = req_i.write_data;
            count_d = req_i.write_data;
          end
          rtcm_pkg::OFS_CONTROL: begin
            if (wbit) run_en_d = 1'b1;  // enable is sticky until reset
          end
          rtcm_pkg::OFS_MASK:  mask_d = wbit;
          rtcm_pkg::OFS_CLEAR: begin
            if (wbit) raw_d = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign res_o.read_data = rdata;
  assign res_o.alarm_hit = hit;
  assign res_o.irq_level = raw_d & mask_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      match_q  <= '0;
      load_q   <= '0;
      run_en_q <= 1'b0;
      mask_q   <= 1'b0;
      raw_q    <= 1'b0;
    end else if (exec_i) begin
      count_q  <= count_d;
      match_q  <= match_d;
      load_q   <= load_d;
      run_en_q <= run_en_d;
      mask_q   <= mask_d;
      raw_q    <= raw_d;
    end
  end

`ifndef SYNTHESIS
  a_run_en_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(run_en_q))
    else $error("run enable cleared without reset");

  a_hit_sets_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && res_o.alarm_hit |=> raw_q)
    else $error("alarm hit did not set raw alarm");

  a_rdata_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && (res_o.read_data != '0) |->
      (req_i.opcode == rtcm_pkg::OP_READ))
    else $error("nonzero read data on a non-read request");

  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_i |=> $stable(count_q) && $stable(raw_q))
    else $error("state changed without an executed request");
`endif

endmodule

// ----- design/rtcm_out_stage.sv -----
`timescale 1ns / 1ps
// Result register: holds one result until the receiver takes it.
// Depends on rtcm_pkg.
module rtcm_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  rtcm_pkg::res_t res_i,
  output logic           slot_free_o,
  output logic           valid_o,
  input  logic           ready_i,
  output rtcm_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  rtcm_pkg::res_t res_q;

  assign slot_free_o = ~valid_q | ready_i;
  assign valid_o     = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- design/rtc_match_counter_regs.sv -----
`timescale 1ns / 1ps
// Top level of the RTC match-counter register block.
// Depends on rtcm_pkg, rtcm_if, rtcm_in_stage, rtcm_regs, rtcm_out_stage.
//
// Usage:
//  - req_i carries one request per handshake: a tick, a register read or a
//    register write (opcode, reg_offset, write_data). Accepted on valid & ready.
//  - rsp_o returns exactly one result per request, in order: read_data,
//    alarm_hit (this tick reached the match value) and irq_level (raw alarm
//    and mask after the request).
//  - Path: the accepting edge loads the input register; the request then
//    executes once the result register is free, and that edge loads the
//    decode and state update into the result register, making the result valid.
//  - Throughput: one request per cycle while results are taken. The counter
//    increment, match compare and read mux sit between input and result registers.
//  - Stall: while a result waits, the block still takes one more request into
//    its input register; ready drops only when both registers are full and
//    the receiver is not taking the result.
//  - Reset (rst_ni low, async): all registers read zero, counter stopped,
//    alarm and mask clear, both channel registers empty.
//  - Control bit 0 only sets the run enable; reset is the only way to stop it.
module rtc_match_counter_regs (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtcm_req_if.sink   req_i,
  rtcm_rsp_if.source rsp_o
);

  rtcm_pkg::req_t req_in;
  rtcm_pkg::req_t req_held;
  rtcm_pkg::res_t res_core;
  rtcm_pkg::res_t res_out;
  logic           slot_free;
  logic           exec;
  logic           in_ready;
  logic           out_valid;

  assign req_in.opcode     = req_i.opcode;
  assign req_in.reg_offset = req_i.reg_offset;
  assign req_in.write_data = req_i.write_data;
  assign req_i.ready       = in_ready;

  rtcm_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (req_i.valid),
    .ready_o     (in_ready),
    .req_i       (req_in),
    .slot_free_i (slot_free),
    .exec_o      (exec),
    .req_o       (req_held)
  );

  // State updates only when the request actually moves into the result register.
  rtcm_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .req_i  (req_held),
    .res_o  (res_core)
  );

  rtcm_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (exec),
    .res_i       (res_core),
    .slot_free_o (slot_free),
    .valid_o     (out_valid),
    .ready_i     (rsp_o.ready),
    .res_o       (res_out)
  );

  assign rsp_o.valid     = out_valid;
  assign rsp_o.read_data = res_out.read_data;
  assign rsp_o.alarm_hit = res_out.alarm_hit;
  assign rsp_o.irq_level = res_out.irq_level;

endmodule

// ----- test/tb_rtc_match_counter_regs.sv -----
`timescale 1ns / 1ps
// Self-checking bench for rtc_match_counter_regs: a queue-fed request driver,
// a result monitor and an in-bench register/counter predictor.
// Depends on rtcm_pkg, rtcm_if and the block itself.
module tb_rtc_match_counter_regs;
  import rtcm_pkg::*;

  // The fourth opcode is a no-op; the package leaves it unnamed
  localparam logic [OpW-1:0] OP_NOP = 2'd3;

  localparam int unsigned RandomItems = 1200;
  localparam int unsigned IdleLimit   = 1000;  // cycles with no handshake at all
  localparam int unsigned LongHold    = 120;   // receiver hold-off that fills the block
  localparam int unsigned MaxReports  = 40;

  // Every mapped register, for random picks
  localparam logic [OfsW-1:0] RegMap [8] = '{OFS_DATA, OFS_MATCH, OFS_LOAD, OFS_CONTROL,
                                             OFS_MASK, OFS_RAW, OFS_MASKED, OFS_CLEAR};

  typedef struct {
    req_t        req;
    int unsigned gap;          // idle cycles before the request is offered
    bit          wait_drain;   // hold it until every outstanding result is back
  } rtc_request_slot_t;

  logic clk_i;
  logic rst_ni;

  rtcm_req_if req_if ();
  rtcm_rsp_if rsp_if ();

  rtc_match_counter_regs u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // ---------------------------------------------------------------------------
  // Predicted register file and counter
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] cnt_q;
  logic [DataW-1:0] match_q;
  logic [DataW-1:0] load_q;
  logic             run_en_q;
  logic             irq_mask_q;
  logic             alarm_raw_q;

  rtc_request_slot_t pending_requests[$];
  res_t              rtc_results_due[$];

  int unsigned queued_cnt;
  int unsigned err_cnt;
  bit          sender_tight;       // no sender gaps for the current stretch
  bit          pause_before_next;  // next queued request waits for a drained block

  // Applies one request to the predicted state and returns the result it causes.
  function automatic res_t apply_rtc_request(input req_t r);
    res_t res;
    res = '0;
    case (r.opcode)
      OP_TICK: begin
        // counter runs only once enabled; the alarm is raised by a tick alone
        if (run_en_q) begin
          cnt_q = cnt_q + 1'b1;
          if (cnt_q == match_q) begin
            alarm_raw_q   = 1'b1;
            res.alarm_hit = 1'b1;
          end
        end
      end
      OP_READ: begin
        case (r.reg_offset)
          OFS_DATA:    res.read_data = cnt_q;
          OFS_MATCH:   res.read_data = match_q;
          OFS_LOAD:    res.read_data = load_q;
          OFS_CONTROL: res.read_data = DataW'(run_en_q);
          OFS_MASK:    res.read_data = DataW'(irq_mask_q);
          OFS_RAW:     res.read_data = DataW'(alarm_raw_q);
          OFS_MASKED:  res.read_data = DataW'(alarm_raw_q & irq_mask_q);
          default:     res.read_data = '0;  // clear register and holes read zero
        endcase
      end
      OP_WRITE: begin
        case (r.reg_offset)
          OFS_MATCH:   match_q = r.write_data;
          OFS_LOAD: begin
            // seeds the counter without a match compare
            load_q = r.write_data;
            cnt_q  = r.write_data;
          end
          OFS_CONTROL: if (r.write_data[FlagBit]) run_en_q = 1'b1;  // set only
          OFS_MASK:    irq_mask_q = r.write_data[FlagBit];
          OFS_CLEAR:   if (r.write_data[FlagBit]) alarm_raw_q = 1'b0;
          default:     ;  // read-only registers and holes ignore writes
        endcase
      end
      default: ;  // no-op opcode
    endcase
    res.irq_level = alarm_raw_q & irq_mask_q;
    return res;
  endfunction

  // Appends a request to the driver queue with an idle gap, drawn at random unless the sender runs tight.
  task automatic queue_request(input logic [OpW-1:0] op, input logic [OfsW-1:0] ofs,
                               input logic [DataW-1:0] data);
    rtc_request_slot_t slot;
    slot.req.opcode     = op;
    slot.req.reg_offset = ofs;
    slot.req.write_data = data;
    slot.gap            = sender_tight ? 0 : $urandom_range(0, 14);
    slot.wait_drain     = pause_before_next;
    pause_before_next   = 1'b0;
    pending_requests.push_back(slot);
    queued_cnt++;
  endtask

  // Mostly a mapped register, now and then any byte offset.
  function automatic logic [OfsW-1:0] pick_offset();
    if ($urandom_range(0, 4) == 0) return OfsW'($urandom_range(0, 255));
    return RegMap[$urandom_range(0, 7)];
  endfunction

  task automatic note_mismatch(input string what, input logic [DataW-1:0] exp_v,
                               input logic [DataW-1:0] act_v);
    err_cnt++;
    if (err_cnt <= MaxReports)
      $display("%0t ns: %s differs, expected %h, got %h", $time, what, exp_v, act_v);
  endtask

  // ---------------------------------------------------------------------------
  // Clock; every block input is known from time zero
  // ---------------------------------------------------------------------------
  initial begin
    clk_i              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.opcode      = '0;
    req_if.reg_offset  = '0;
    req_if.write_data  = '0;
    rsp_if.ready       = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Request driver: offers the queue head once its gap has elapsed
  // ---------------------------------------------------------------------------
  int unsigned gap_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.opcode     <= '0;
      req_if.reg_offset <= '0;
      req_if.write_data <= '0;
      gap_cnt           <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        rtc_results_due.push_back(apply_rtc_request(pending_requests[0].req));
        void'(pending_requests.pop_front());
      end
      // channel free: either nothing offered or the offer was just taken
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() == 0 ||
            (pending_requests[0].wait_drain && rtc_results_due.size() != 0)) begin
          req_if.valid <= 1'b0;
        end else if (gap_cnt < pending_requests[0].gap) begin
          req_if.valid <= 1'b0;
          gap_cnt      <= gap_cnt + 1;
        end else begin
          req_if.valid      <= 1'b1;
          req_if.opcode     <= pending_requests[0].req.opcode;
          req_if.reg_offset <= pending_requests[0].req.reg_offset;
          req_if.write_data <= pending_requests[0].req.write_data;
          gap_cnt           <= 0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks in order, then draws its own stall for the next one
  // ---------------------------------------------------------------------------
  int unsigned rsp_cnt;
  int unsigned stall_cnt;

  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    res_t        exp_res;
    int unsigned stall;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_cnt    <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      if (rtc_results_due.size() == 0) begin
        note_mismatch("unrequested result read_data", '0, rsp_if.read_data);
      end else begin
        exp_res = rtc_results_due.pop_front();
        if (rsp_if.read_data !== exp_res.read_data)
          note_mismatch("read_data", exp_res.read_data, rsp_if.read_data);
        if (rsp_if.alarm_hit !== exp_res.alarm_hit)
          note_mismatch("alarm_hit", DataW'(exp_res.alarm_hit), DataW'(rsp_if.alarm_hit));
        if (rsp_if.irq_level !== exp_res.irq_level)
          note_mismatch("irq_level", DataW'(exp_res.irq_level), DataW'(rsp_if.irq_level));
      end
      rsp_cnt++;
      // one long hold-off backs the block up; some stretches run without stalls
      if (rsp_cnt == 400)
        stall = LongHold;
      else if ((rsp_cnt / 150) % 4 == 2)
        stall = 0;
      else
        stall = $urandom_range(0, 14);
      rsp_if.ready <= (stall == 0);
      stall_cnt    <= stall;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      if (stall_cnt == 1) rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no handshake on either side for too long ends the run
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("rtc_match_counter_regs: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin
    logic [DataW-1:0] base;
    int unsigned      burst;
    bit               paused_once;
    cnt_q             = '0;
    match_q           = '0;
    load_q            = '0;
    run_en_q          = 1'b0;
    irq_mask_q        = 1'b0;
    alarm_raw_q       = 1'b0;
    queued_cnt        = 0;
    err_cnt           = 0;
    rsp_cnt           = 0;
    sender_tight      = 1'b0;
    pause_before_next = 1'b0;
    paused_once       = 1'b0;

    rst_ni = 1'b0;

    // Directed: reset values, stopped counter, set-only enable, load without
    // compare, wrap onto the match, repeated hit, clear, holes and the no-op
    queue_request(OP_READ,  OFS_DATA,    '0);
    queue_request(OP_READ,  8'hFF,       '0);
    queue_request(OP_TICK,  8'hFF,       32'hFFFF_FFFF);   // counter still stopped
    queue_request(OP_WRITE, OFS_CONTROL, 32'hFFFF_FFFE);   // bit 0 low: stays stopped
    queue_request(OP_READ,  OFS_CONTROL, '0);
    queue_request(OP_WRITE, OFS_MATCH,   32'd5);
    queue_request(OP_WRITE, OFS_LOAD,    32'd5);           // equals match, no alarm
    queue_request(OP_READ,  OFS_RAW,     '0);
    queue_request(OP_WRITE, OFS_CONTROL, 32'd1);
    queue_request(OP_WRITE, OFS_MASK,    32'hFFFF_FFFF);
    queue_request(OP_WRITE, OFS_LOAD,    32'hFFFF_FFFF);
    queue_request(OP_WRITE, OFS_MATCH,   32'h0);
    queue_request(OP_TICK,  '0,          '0);              // wraps onto match
    queue_request(OP_WRITE, OFS_LOAD,    32'hFFFF_FFFF);
    queue_request(OP_TICK,  '0,          '0);              // hit with alarm already set
    queue_request(OP_READ,  OFS_MASKED,  '0);
    queue_request(OP_READ,  OFS_CLEAR,   '0);
    queue_request(OP_WRITE, OFS_CLEAR,   32'hFFFF_FFFE);   // bit 0 low: no clear
    queue_request(OP_WRITE, OFS_CLEAR,   32'd1);
    queue_request(OP_READ,  OFS_RAW,     '0);
    queue_request(OP_WRITE, OFS_DATA,    32'hA5A5_A5A5);   // read-only, ignored
    queue_request(OP_WRITE, 8'hFF,       32'hFFFF_FFFF);   // hole, ignored
    queue_request(OP_NOP,   OFS_LOAD,    32'hFFFF_FFFF);
    queue_request(OP_WRITE, OFS_CONTROL, 32'h0);           // cannot stop the counter
    queue_request(OP_READ,  OFS_LOAD,    '0);

    // Random: mostly alarm scenarios (seed the counter, place the match a few
    // ticks ahead, run), the rest scattered accesses and noise
    while (queued_cnt < RandomItems + 25) begin
      if (queued_cnt % 100 < 10) sender_tight = ($urandom_range(0, 3) == 0);
      if (queued_cnt >= 700 && !paused_once) begin
        pause_before_next = 1'b1;
        paused_once       = 1'b1;
      end
      if ($urandom_range(0, 9) < 6) begin
        base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4) : $urandom;
        queue_request(OP_WRITE, OFS_LOAD, base);
        queue_request(OP_WRITE, OFS_MATCH, base + $urandom_range(1, 6));
        if ($urandom_range(0, 2) == 0) queue_request(OP_WRITE, OFS_MASK, $urandom);
        burst = $urandom_range(3, 10);
        repeat (burst) begin
          case ($urandom_range(0, 9))
            0, 1:    queue_request(OP_READ, pick_offset(), $urandom);
            2:       queue_request(OP_WRITE, OFS_CLEAR, $urandom);
            3:       queue_request(OP_WRITE, OFS_CONTROL, $urandom);
            default: queue_request(OP_TICK, OfsW'($urandom_range(0, 255)), $urandom);
          endcase
        end
      end else begin
        queue_request(OpW'($urandom_range(0, 3)), pick_offset(), $urandom);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || rtc_results_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("rtc_match_counter_regs: match");
    end else begin
      $display("rtc_match_counter_regs: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rtcm_pkg.sv
design/rtcm_if.sv
design/rtcm_in_stage.sv
design/rtcm_regs.sv
design/rtcm_out_stage.sv
design/rtc_match_counter_regs.sv
test/tb_rtc_match_counter_regs.sv
